### design/sobel_gradient_magnitude_squared_defines.svh
// ---------------------------------------------------------------------------
// sobel gradient magnitude squared: assertion macros
// shared property forms for the block's concurrent checks
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_SQUARED_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_SQUARED_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SGM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SGM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sgm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_pkg
// widths, limits, register codes and shared types of the sobel block
// ---------------------------------------------------------------------------
package sgm_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_DIM    = 3;

	localparam int PIX_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WREG_W = 11;
	localparam int HREG_W = 13;
	localparam int CFG_W  = 13;
	localparam int CFG_IDX_W = 1;
	localparam int SUM_W  = PIX_W + 2;
	localparam int GRAD_W = SUM_W + 1;
	localparam int SQ_W   = 20;
	localparam int MAG_W  = 21;

	localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
	localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             emit;
	} pos_t;

	typedef struct packed {
		logic shift;
		logic load_s2;
		logic load_s3;
	} pipe_ctl_t;

	typedef struct packed {
		logic [SQ_W-1:0]  sqx;
		logic [SQ_W-1:0]  sqy;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} grad_t;

endpackage

### design/sgm_pixel_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_pixel_if
// pixel channel: one grayscale pixel and its frame-start mark per word
// ---------------------------------------------------------------------------
interface sgm_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

### design/sgm_result_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_result_if
// result channel: squared gradient magnitude and centre position per word
// ---------------------------------------------------------------------------
interface sgm_result_if;
	logic        valid;
	logic        ready;
	logic [20:0] magnitude_sq;
	logic [11:0] out_row;
	logic [9:0]  out_col;

	modport source (output valid, output magnitude_sq, output out_row, output out_col,
		input ready);
	modport sink (input valid, input magnitude_sq, input out_row, input out_col,
		output ready);
endinterface

### design/sgm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/sgm_position.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_position
// raster position counters with frame start, wrap and size clamping
// ---------------------------------------------------------------------------
module sgm_position import sgm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              frame_start,
	input  logic [WREG_W-1:0] image_width,
	input  logic [HREG_W-1:0] image_height,
	output pos_t              cur
);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WREG_W-1:0] w_lim;
	logic [HREG_W-1:0] h_lim;
	logic [COL_W-1:0]  c0;
	logic [HREG_W-1:0] r0;
	logic [HREG_W-1:0] r1;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic [WREG_W-1:0] c_inc;
	logic [HREG_W-1:0] r_inc;
	logic [COL_W-1:0]  col_d;
	logic [ROW_W-1:0]  row_d;

	always_comb begin
		if (image_width < WREG_W'(MIN_DIM)) begin
			w_lim = WREG_W'(MIN_DIM);
		end else if (image_width > WREG_W'(MAX_WIDTH)) begin
			w_lim = WREG_W'(MAX_WIDTH);
		end else begin
			w_lim = image_width;
		end
		if (image_height < HREG_W'(MIN_DIM)) begin
			h_lim = HREG_W'(MIN_DIM);
		end else if (image_height > HREG_W'(MAX_HEIGHT)) begin
			h_lim = HREG_W'(MAX_HEIGHT);
		end else begin
			h_lim = image_height;
		end

		// position of the incoming word
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : HREG_W'(row_q);
		if (WREG_W'(c0) >= w_lim) begin
			col = '0;
			r1  = r0 + HREG_W'(1);
		end else begin
			col = c0;
			r1  = r0;
		end
		row = (r1 >= h_lim) ? '0 : r1[ROW_W-1:0];

		// position of the word after it
		c_inc = WREG_W'(col) + WREG_W'(1);
		r_inc = HREG_W'(row) + HREG_W'(1);
		if (c_inc >= w_lim) begin
			col_d = '0;
			row_d = (r_inc >= h_lim) ? '0 : r_inc[ROW_W-1:0];
		end else begin
			col_d = c_inc[COL_W-1:0];
			row_d = row;
		end

		cur.row  = row;
		cur.col  = col;
		cur.emit = (row >= ROW_W'(2)) && (col >= COL_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

### design/sgm_kernel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_kernel
// 3x3 window, sobel responses and their squares over two pipeline stages
// ---------------------------------------------------------------------------
module sgm_kernel import sgm_pkg::*; (
	input  logic             clk,
	input  pipe_ctl_t        ctl,
	input  logic [PIX_W-1:0] upper,
	input  logic [PIX_W-1:0] middle,
	input  logic [PIX_W-1:0] px,
	input  pos_t             pos,
	output grad_t            res_s3
);

	// [row][col], col 1 is the newer of the two kept columns
	logic [PIX_W-1:0] win_q [3][2];
	logic [PIX_W-1:0] col_new [3];

	logic [SUM_W-1:0] sum_l;
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_t;
	logic [SUM_W-1:0] sum_b;
	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;

	logic signed [GRAD_W-1:0] gx_s2;
	logic signed [GRAD_W-1:0] gy_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic signed [2*GRAD_W-1:0] sqx_full;
	logic signed [2*GRAD_W-1:0] sqy_full;

	assign col_new[0] = upper;
	assign col_new[1] = middle;
	assign col_new[2] = px;

	always_comb begin
		sum_l = SUM_W'(win_q[0][0]) + {1'b0, win_q[1][0], 1'b0} + SUM_W'(win_q[2][0]);
		sum_r = SUM_W'(upper) + {1'b0, middle, 1'b0} + SUM_W'(px);
		sum_t = SUM_W'(win_q[0][0]) + {1'b0, win_q[0][1], 1'b0} + SUM_W'(upper);
		sum_b = SUM_W'(win_q[2][0]) + {1'b0, win_q[2][1], 1'b0} + SUM_W'(px);
		gx = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= col_new[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			gx_s2  <= gx;
			gy_s2  <= gy;
			row_s2 <= pos.row - ROW_W'(1);
			col_s2 <= pos.col - COL_W'(1);
		end
	end

	assign sqx_full = gx_s2 * gx_s2;
	assign sqy_full = gy_s2 * gy_s2;

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			res_s3.sqx <= sqx_full[SQ_W-1:0];
			res_s3.sqy <= sqy_full[SQ_W-1:0];
			res_s3.row <= row_s2;
			res_s3.col <= col_s2;
		end
	end

endmodule

### design/sobel_gradient_magnitude_squared.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude_squared
// streaming 3x3 sobel edge detector giving gx*gx + gy*gy per interior pixel
// ---------------------------------------------------------------------------
// Takes one pixel word per clock and gives one result word per clock at most,
// unless results.ready stalls the pipeline or the line stores are being cleared.
// The word completing the window reaches the result through the line store read,
// gradient, squares and output register stages. Each line store is a
// single-port-write ram written once per pixel, which sets the rate of one
// pixel per cycle. After reset all 1024 addresses of both line stores are
// cleared, one address per cycle; pixels.ready stays low meanwhile, configuration writes are taken.
`include "sobel_gradient_magnitude_squared_defines.svh"

module sobel_gradient_magnitude_squared import sgm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sgm_pixel_if.sink            pixels,
	sgm_result_if.source         results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [WREG_W-1:0] image_width_q;
	logic [HREG_W-1:0] image_height_q;

	logic             clr_busy_q;
	logic [COL_W-1:0] clr_addr_q;

	logic en_out;
	logic en_s3;
	logic en_s2;
	logic en_s1;
	logic accept;

	pos_t             cur;
	logic             valid_s1;
	logic [PIX_W-1:0] px_s1;
	pos_t             pos_s1;
	logic             valid_s2;
	logic             valid_s3;

	logic [PIX_W-1:0] upper_rd;
	logic [PIX_W-1:0] middle_rd;
	logic [PIX_W-1:0] upper_eff;
	logic [PIX_W-1:0] middle_eff;
	logic             byp_q;
	logic [PIX_W-1:0] byp_upper_q;
	logic [PIX_W-1:0] byp_middle_q;

	logic             ram_we;
	logic [COL_W-1:0] ram_waddr;
	logic [PIX_W-1:0] upper_wdata;
	logic [PIX_W-1:0] middle_wdata;

	pipe_ctl_t ctl;
	grad_t     res_s3;

	logic             out_valid_q;
	logic [MAG_W-1:0] mag_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WREG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HREG_W-1:0];
				default: ;
			endcase
		end
	end

	// line store clearing after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + COL_W'(1);
			if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// stage enables
	assign en_out = !out_valid_q || results.ready;
	assign en_s3  = !valid_s3 || en_out;
	assign en_s2  = !valid_s2 || en_s3;
	assign en_s1  = !valid_s1 || en_s2;
	assign pixels.ready = en_s1 && !clr_busy_q;
	assign accept = pixels.valid && pixels.ready;

	assign ctl.shift   = valid_s1 && en_s2;
	assign ctl.load_s2 = en_s2;
	assign ctl.load_s3 = en_s3;

	sgm_position u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.frame_start  (pixels.frame_start),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.cur          (cur)
	);

	// line stores
	assign upper_eff  = byp_q ? byp_upper_q : upper_rd;
	assign middle_eff = byp_q ? byp_middle_q : middle_rd;

	assign ram_we       = clr_busy_q || ctl.shift;
	assign ram_waddr    = clr_busy_q ? clr_addr_q : pos_s1.col;
	assign upper_wdata  = clr_busy_q ? '0 : middle_eff;
	assign middle_wdata = clr_busy_q ? '0 : px_s1;

	sgm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (upper_wdata),
		.re    (en_s1),
		.raddr (cur.col),
		.rdata (upper_rd)
	);

	sgm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (middle_wdata),
		.re    (en_s1),
		.raddr (cur.col),
		.rdata (middle_rd)
	);

	// stage 1 and write-to-read forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_q    <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept;
			byp_q    <= accept && ctl.shift && (cur.col == pos_s1.col);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pixels.pixel;
			pos_s1       <= cur;
			byp_upper_q  <= middle_eff;
			byp_middle_q <= px_s1;
		end
	end

	sgm_kernel u_kernel (
		.clk    (clk),
		.ctl    (ctl),
		.upper  (upper_eff),
		.middle (middle_eff),
		.px     (px_s1),
		.pos    (pos_s1),
		.res_s3 (res_s3)
	);

	// result valids and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= valid_s1 && pos_s1.emit;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			mag_q     <= MAG_W'(res_s3.sqx) + MAG_W'(res_s3.sqy);
			out_row_q <= res_s3.row;
			out_col_q <= res_s3.col;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.magnitude_sq = mag_q;
	assign results.out_row      = out_row_q;
	assign results.out_col      = out_col_q;

	// checks
	`SGM_ASSERT_NOW(a_no_pixel_while_clearing, clr_busy_q, !valid_s1 && !pixels.ready, "word in clear")
	`SGM_ASSERT_NOW(a_bypass_needs_item, byp_q, valid_s1, "forwarding with empty stage 1")
	`SGM_ASSERT_NOW(a_centre_interior, results.valid, (out_row_q != '0) && (out_col_q != '0), "border")
	`SGM_ASSERT_NEXT(a_emit_reaches_s2, valid_s1 && pos_s1.emit && en_s2, valid_s2, "word lost")

endmodule

### dv/sgm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_checker
// watches the pixel and result channels and the register port, keeps its own
// line stores, window and position, and compares each result word with the
// squared sobel magnitude it predicts, field by field, oldest first
// ---------------------------------------------------------------------------
module sgm_checker import sgm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sgm_pixel_if                 pixels,
	sgm_result_if                results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [MAG_W-1:0] magnitude_sq;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} gradient_t;

	gradient_t         gradients_due[$];
	logic [PIX_W-1:0]  two_rows_up [MAX_WIDTH];
	logic [PIX_W-1:0]  one_row_up [MAX_WIDTH];
	logic [PIX_W-1:0]  win [3][3];
	int unsigned       next_col;
	int unsigned       next_row;
	logic [WREG_W-1:0] width_reg;
	logic [HREG_W-1:0] height_reg;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < MIN_DIM)
			return MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic take_pixel(input logic [PIX_W-1:0] px, input logic fs);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		int gx;
		int gy;
		gradient_t g;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		if (fs) begin
			next_col = 0;
			next_row = 0;
		end
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
		end
		if (next_row >= h)
			next_row = 0;
		col = next_col;
		row = next_row;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = two_rows_up[col];
		win[1][2] = one_row_up[col];
		win[2][2] = px;
		two_rows_up[col] = one_row_up[col];
		one_row_up[col] = px;
		if (row >= 2 && col >= 2) begin
			gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
				- (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
			gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
				- (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
			g.magnitude_sq = MAG_W'(gx * gx + gy * gy);
			g.row = ROW_W'(row - 1);
			g.col = COL_W'(col - 1);
			gradients_due.push_back(g);
		end
		next_col = col + 1;
		if (next_col >= w) begin
			next_col = 0;
			next_row = row + 1;
			if (next_row >= h)
				next_row = 0;
		end
	endtask

	task automatic check_result();
		gradient_t e;
		if (gradients_due.size() == 0) begin
			$error("unexpected result word: magnitude_sq %0d, out_row %0d, out_col %0d",
				results.magnitude_sq, results.out_row, results.out_col);
			fail_count++;
		end else begin
			e = gradients_due.pop_front();
			if (results.magnitude_sq !== e.magnitude_sq) begin
				$error("magnitude_sq mismatch: expected %0d, actual %0d",
					e.magnitude_sq, results.magnitude_sq);
				fail_count++;
			end
			if (results.out_row !== e.row) begin
				$error("out_row mismatch: expected %0d, actual %0d", e.row, results.out_row);
				fail_count++;
			end
			if (results.out_col !== e.col) begin
				$error("out_col mismatch: expected %0d, actual %0d", e.col, results.out_col);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				two_rows_up[i] = '0;
				one_row_up[i] = '0;
			end
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win[r][c] = '0;
			next_col = 0;
			next_row = 0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			gradients_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_data[WREG_W-1:0];
				else if (cfg_index == REG_IMAGE_HEIGHT)
					height_reg = cfg_data[HREG_W-1:0];
			end
			if (results.valid && results.ready)
				check_result();
			if (pixels.valid && pixels.ready)
				take_pixel(pixels.pixel, pixels.frame_start);
			pending = gradients_due.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// regression for the sobel block: directed frames on the smallest image,
// register values out of range and at the largest sizes, then random frames,
// whole, cut short, run past the end or with stray frame starts, under
// random gaps and stalls on both channels
// ---------------------------------------------------------------------------
module tb;
	import sgm_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending;
	bit                   send_idle;
	bit                   recv_idle;
	int unsigned          width_val;
	int unsigned          height_val;
	int unsigned          w_eff;
	int unsigned          h_eff;
	int unsigned          pixels_sent;

	sgm_pixel_if  pix_ch ();
	sgm_result_if res_ch ();

	sobel_gradient_magnitude_squared dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_ch),
		.results   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sgm_checker gradient_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pix_ch),
		.results    (res_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	function automatic int idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side stalls
	initial begin : result_stalls
		int hold;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else begin
				res_ch.ready <= 1'b1;
				if (recv_idle && $urandom_range(0, 3) == 0)
					hold = idle_length();
			end
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
		int gap;
		gap = (send_idle && $urandom_range(0, 3) == 0) ? idle_length() : 0;
		@(negedge clk);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		pix_ch.frame_start <= fs;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	// kind 0: any value, 1: black or white only, 2: near-flat grey
	task automatic send_run(input int unsigned count, input bit with_start, input bit noise,
		input int kind);
		logic [PIX_W-1:0] px;
		logic             fs;
		for (int unsigned i = 0; i < count; i++) begin
			case (kind)
				0: px = PIX_W'($urandom_range(0, 255));
				1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default: px = PIX_W'($urandom_range(118, 137));
			endcase
			fs = (i == 0 && with_start) || (noise && $urandom_range(0, 19) == 0);
			send_pixel(px, fs);
		end
	endtask

	task automatic wait_results_clear();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// let the pipeline empty before touching the registers
	task automatic reconfigure(input bit set_w, input int unsigned w, input bit set_h,
		input int unsigned h);
		wait_results_clear();
		repeat (16) @(negedge clk);
		if (set_w) begin
			write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
			width_val = w;
		end
		if (set_h) begin
			write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
			height_val = h;
		end
		w_eff = width_val < MIN_DIM ? MIN_DIM : (width_val > MAX_WIDTH ? MAX_WIDTH : width_val);
		h_eff = height_val < MIN_DIM ? MIN_DIM :
			(height_val > MAX_HEIGHT ? MAX_HEIGHT : height_val);
	endtask

	initial begin : stimulus
		int unsigned random_floor;
		int unsigned frame_len;
		int unsigned r;
		int unsigned nw;
		int unsigned nh;
		int kind;
		int waited;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		pix_ch.frame_start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		width_val = WIDTH_RESET;
		height_val = HEIGHT_RESET;
		pixels_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest image, taken during the clearing pass
		write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
		width_val = 3;
		height_val = 3;
		w_eff = 3;
		h_eff = 3;

		// first frame with no frame start mark
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		wait_results_clear();
		// past the frame end, then a frame start part way into the row
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_pixel(8'd17, 1'b1);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);

		// registers below the minimum act as three
		reconfigure(1'b1, 0, 1'b1, 2);
		send_run(9, 1'b1, 1'b0, 1);
		reconfigure(1'b1, 1, 1'b1, 1);
		send_run(12, 1'b1, 1'b0, 0);

		// widest row, first part of it
		reconfigure(1'b1, MAX_WIDTH, 1'b1, 3);
		send_run(40, 1'b1, 1'b0, 0);

		// tallest frame, first rows of it
		reconfigure(1'b1, 3, 1'b1, MAX_HEIGHT);
		send_run(48, 1'b1, 1'b0, 1);

		// above the maximum, then narrowed mid-row
		reconfigure(1'b1, 2047, 1'b1, 8191);
		send_run(60, 1'b1, 1'b0, 0);
		reconfigure(1'b1, 5, 1'b0, 0);
		send_run(40, 1'b0, 1'b0, 0);

		random_floor = pixels_sent + 400;
		while (pixels_sent < random_floor) begin
			r = $urandom_range(0, 99);
			nw = r < 80 ? $urandom_range(3, 8) : (r < 90 ? $urandom_range(0, 2) :
				$urandom_range(9, 40));
			r = $urandom_range(0, 99);
			nh = r < 80 ? $urandom_range(3, 6) : (r < 90 ? $urandom_range(0, 2) :
				$urandom_range(4097, 8191));
			r = $urandom_range(0, 3);
			reconfigure(r != 1, nw, r != 2, nh);
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(1, 3)) begin
				frame_len = w_eff * h_eff;
				if (frame_len > 200)
					frame_len = $urandom_range(40, 160);
				kind = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2);
				r = $urandom_range(0, 9);
				if (r < 7)
					send_run(frame_len, 1'b1, 1'b0, kind);
				else if (r < 8)
					send_run($urandom_range(1, frame_len), 1'b1, 1'b0, kind);
				else if (r < 9)
					send_run($urandom_range(1, 2 * frame_len), 1'b0, 1'b1, kind);
				else
					send_run(frame_len + $urandom_range(1, w_eff), 1'b0, 1'b0, kind);
				if ($urandom_range(0, 19) == 0)
					wait_results_clear();
			end
		end

		@(negedge clk);
		pix_ch.valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);
		if (pending != 0)
			$error("%0d result words never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("sobel_gradient_magnitude_squared regression: pass");
		else
			$display("sobel_gradient_magnitude_squared regression: fail");
		$finish;
	end

	initial begin : watchdog
		#80_000_000;
		$display("sobel_gradient_magnitude_squared regression: fail");
		$finish;
	end

endmodule
